/* rtl/bdlp_pkg.sv */
// ----------------------------------------------------------------------------
// bdlp_pkg
// Shared types and constants for the button debouncer with long-press detect.
// ----------------------------------------------------------------------------
package bdlp_pkg;

  localparam int unsigned TimeW     = 32;
  localparam int unsigned DebounceW = 16;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned InDataW   = 40;
  localparam int unsigned OutDataW  = 8;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgDebounceMs = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgHoldMs     = 1'd1;

  // Reset values of the configuration registers.
  localparam logic [DebounceW-1:0] DebounceMsReset = 16'd50;
  localparam logic [TimeW-1:0]     HoldMsReset     = 32'd1000;

  // One sample tick.
  typedef struct packed {
    logic             pin_level;
    logic [TimeW-1:0] now_ms;
  } item_t;

  // One evaluation result.
  typedef struct packed {
    logic held;
    logic released;
    logic held_long;
    logic held_long_once;
  } result_t;

endpackage

/* rtl/bdlp_core.sv */
// ----------------------------------------------------------------------------
// bdlp_core
// Debounce and long-hold evaluation with its state and configuration.
// ----------------------------------------------------------------------------
module bdlp_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [bdlp_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [bdlp_pkg::CfgDataW-1:0]   cfg_wdata,
  input  logic                            step_en,
  input  bdlp_pkg::item_t                 item,
  output bdlp_pkg::result_t               result
);
  import bdlp_pkg::*;

  logic [DebounceW-1:0] debounce_ms_r;
  logic [TimeW-1:0]     hold_ms_r;

  logic             last_level_r,   last_level_nxt;
  logic [TimeW-1:0] change_time_r,  change_time_nxt;
  logic             was_held_r,     was_held_nxt;
  logic [TimeW-1:0] hold_start_r,   hold_start_nxt;
  logic             hold_running_r, hold_running_nxt;
  logic [TimeW-1:0] hold_elapsed_r, hold_elapsed_nxt;
  logic             long_fired_r,   long_fired_nxt;

  logic [TimeW-1:0] stable_time;
  logic             held;
  logic             longh;

  always_comb begin
    change_time_nxt = (item.pin_level != last_level_r) ? item.now_ms : change_time_r;
    last_level_nxt  = item.pin_level;
    stable_time     = item.now_ms - change_time_nxt;
    held            = (stable_time > {{(TimeW-DebounceW){1'b0}}, debounce_ms_r}) &&
                      !item.pin_level;
    was_held_nxt    = held;

    hold_start_nxt   = hold_start_r;
    hold_running_nxt = hold_running_r;
    hold_elapsed_nxt = hold_elapsed_r;
    if (held) begin
      if (!hold_running_r) begin
        hold_start_nxt   = item.now_ms;
        hold_running_nxt = 1'b1;
      end else begin
        hold_elapsed_nxt = item.now_ms - hold_start_r;
      end
    end else begin
      hold_start_nxt   = '0;
      hold_running_nxt = 1'b0;
      hold_elapsed_nxt = '0;
    end

    longh          = held && (hold_elapsed_nxt >= hold_ms_r);
    long_fired_nxt = longh;

    result.held           = held;
    result.released       = !held && was_held_r;
    result.held_long      = longh;
    result.held_long_once = longh && !long_fired_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ms_r <= DebounceMsReset;
      hold_ms_r     <= HoldMsReset;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CfgDebounceMs: debounce_ms_r <= cfg_wdata[DebounceW-1:0];
        CfgHoldMs:     hold_ms_r     <= cfg_wdata[TimeW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r   <= 1'b1;
      change_time_r  <= '0;
      was_held_r     <= 1'b0;
      hold_start_r   <= '0;
      hold_running_r <= 1'b0;
      hold_elapsed_r <= '0;
      long_fired_r   <= 1'b0;
    end else if (step_en) begin
      last_level_r   <= last_level_nxt;
      change_time_r  <= change_time_nxt;
      was_held_r     <= was_held_nxt;
      hold_start_r   <= hold_start_nxt;
      hold_running_r <= hold_running_nxt;
      hold_elapsed_r <= hold_elapsed_nxt;
      long_fired_r   <= long_fired_nxt;
    end
  end

endmodule

/* rtl/button_debounce_long_press.sv */
// ----------------------------------------------------------------------------
// button_debounce_long_press
// Debounces an active-low button and reports release and long-hold events.
// ----------------------------------------------------------------------------
// Each word on the input stream is one sample tick: the raw button level
// (0 means pressed) and a free-running millisecond timestamp. Each tick
// yields exactly one result word on the output stream: held, released,
// held_long and held_long_once, all computed from a single debounce
// evaluation of that tick.
// The tick is first captured in an input register. The evaluation and the
// state update happen in the cycle the registered tick moves into the output
// register, from which the result is offered on the output stream.
// Throughput is one word per cycle while the receiver keeps taking results;
// the only loop is the state update of the evaluation core.
// When the receiver stalls, the finished result waits in the output register
// and one more tick can still be taken into the input register; after that
// in_tready drops until the result is taken.
// Reset (rst_n low at a clock edge) empties both registers, restores the
// configuration to debounce_ms = 50 and hold_ms = 1000, and returns the
// button state to "not pressed". Configuration writes take effect at once
// and belong while no word is in flight.
// ----------------------------------------------------------------------------
module button_debounce_long_press (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input stream. Fields from bit 0: pin_level[0], now_ms[32:1], zero pad.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bdlp_pkg::InDataW-1:0]    in_tdata,
  // Result stream. Fields from bit 0: held, released, held_long,
  // held_long_once, zero pad.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bdlp_pkg::OutDataW-1:0]   out_tdata,
  // Configuration write port.
  input  logic                            cfg_wr_en,
  input  logic [bdlp_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [bdlp_pkg::CfgDataW-1:0]   cfg_wdata
);
  import bdlp_pkg::*;

  // Input register holding one accepted tick.
  logic    in_valid_r;
  item_t   in_item_r;

  // Output register holding one finished result.
  logic    out_valid_r;
  result_t out_res_r;

  result_t eval_res;
  logic    advance;

  // The registered tick moves on whenever the output register is empty or
  // is being emptied in this cycle.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  bdlp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step_en   (advance),
    .item      (in_item_r),
    .result    (eval_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r.pin_level <= in_tdata[0];
      in_item_r.now_ms    <= in_tdata[TimeW:1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= eval_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OutDataW-4){1'b0}}, out_res_r.held_long_once,
                       out_res_r.held_long, out_res_r.released, out_res_r.held};

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the button debouncer with long-press detect.
// ----------------------------------------------------------------------------
// Sample ticks go in on the input stream and are scored against a behavioral
// model of the debouncer that runs inside the bench. Directed tests cover the
// reset configuration, the zero settings, the widest settings with wrapping
// timestamps, and contact bounce. A random test then runs press sequences and
// noise under several register settings. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bdlp_pkg::*;

  // Cycles without any handshake or register write before the run is declared hung.
  localparam int unsigned StallLimit = 4000;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  // Fields from bit 0: pin_level[0], now_ms[32:1], zero pad.
  logic [InDataW-1:0]    in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // Fields from bit 0: held, released, held_long, held_long_once, zero pad.
  logic [OutDataW-1:0]   out_tdata;
  logic                  cfg_wr_en  = 1'b0;
  logic [CfgIdxW-1:0]    cfg_index  = '0;
  logic [CfgDataW-1:0]   cfg_wdata  = '0;

  button_debounce_long_press i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Model copy of the configuration registers, starting at reset values.
  logic [DebounceW-1:0] debounce_cfg = DebounceMsReset;
  logic [TimeW-1:0]     hold_cfg     = HoldMsReset;

  // Model copy of the debouncer state. The button starts released.
  logic             last_level   = 1'b1;
  logic [TimeW-1:0] change_time  = '0;
  logic             was_held     = 1'b0;
  logic [TimeW-1:0] hold_start   = '0;
  logic             hold_active  = 1'b0;
  logic [TimeW-1:0] hold_elapsed = '0;
  logic             long_fired   = 1'b0;

  // Flags predicted for every accepted tick, oldest first.
  result_t expected_flags[$];

  // When set, both stream sides run without gaps.
  bit          calm        = 1'b0;
  int unsigned mismatches  = 0;
  int unsigned stall_count = 0;

  // One debounce evaluation: advances the model state by one tick and returns
  // the flags the block must report for it.
  function automatic result_t evaluate_button(logic level, logic [TimeW-1:0] stamp);
    result_t          r;
    logic [TimeW-1:0] since_change;
    logic             long_now;
    // Any change of the raw level restarts the stability timer.
    if (level != last_level) begin
      change_time = stamp;
    end
    since_change = stamp - change_time;
    // Held needs the low level to be stable strictly longer than debounce_ms.
    r.held = (since_change > {16'd0, debounce_cfg}) && (level == 1'b0);
    last_level = level;
    r.released = !r.held && was_held;
    was_held = r.held;
    if (r.held) begin
      // The first held tick only stamps the start, so elapsed time stays 0.
      if (!hold_active) begin
        hold_start  = stamp;
        hold_active = 1'b1;
      end else begin
        hold_elapsed = stamp - hold_start;
      end
      long_now = (hold_elapsed >= hold_cfg);
    end else begin
      hold_active  = 1'b0;
      hold_start   = '0;
      hold_elapsed = '0;
      long_now     = 1'b0;
    end
    r.held_long      = long_now;
    r.held_long_once = 1'b0;
    // The one-shot fires on the first long tick and re-arms on any tick
    // that is not long.
    if (long_now) begin
      if (!long_fired) begin
        r.held_long_once = 1'b1;
        long_fired       = 1'b1;
      end
    end else begin
      long_fired = 1'b0;
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [3:0] want, logic [3:0] got);
    if (got !== want) begin
      mismatches++;
      $error("%s: expected %0h, actual %0h", name, want, got);
    end
  endfunction

  // Sends one tick after a random gap. The valid stays high when the gap is
  // zero so that back-to-back words are possible.
  task automatic send_tick(input logic level, input logic [TimeW-1:0] stamp);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 17);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, stamp, level};
    do @(posedge clk); while (!in_tready);
    expected_flags.push_back(evaluate_button(level, stamp));
  endtask

  // Stops the input stream and waits until every predicted word has arrived.
  // Each tick yields a word, so the block is idle at that point.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_flags.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CfgDebounceMs) begin
      debounce_cfg = value[DebounceW-1:0];
    end else begin
      hold_cfg = value;
    end
  endtask

  task automatic apply_config(input logic [DebounceW-1:0] deb, input logic [TimeW-1:0] hold);
    wait_drained();
    write_reg(CfgDebounceMs, {16'd0, deb});
    write_reg(CfgHoldMs, hold);
  endtask

  // Reset settings (50 ms, 1000 ms): the debounce boundary at exactly 50 ms,
  // the first held tick, the long hold at exactly 1000 ms and a release.
  task automatic test_reset_defaults();
    send_tick(1'b1, 32'd0);
    send_tick(1'b0, 32'd10);
    send_tick(1'b0, 32'd60);
    send_tick(1'b0, 32'd61);
    send_tick(1'b0, 32'd1061);
    send_tick(1'b0, 32'd1062);
    send_tick(1'b1, 32'd1063);
  endtask

  // Zero settings: held_long comes on the first held tick already, and a
  // repeated timestamp keeps it without a second pulse.
  task automatic test_zero_settings();
    apply_config(16'd0, 32'd0);
    send_tick(1'b0, 32'd5);
    send_tick(1'b0, 32'd6);
    send_tick(1'b0, 32'd6);
    send_tick(1'b1, 32'd7);
  endtask

  // Contact bounce: short glitches restart the stability timer, a release
  // between presses restarts the hold, and the second press then fires the long-hold pulse.
  task automatic test_bounce();
    apply_config(16'd20, 32'd30);
    send_tick(1'b0, 32'd1000);
    send_tick(1'b1, 32'd1005);
    send_tick(1'b0, 32'd1010);
    send_tick(1'b0, 32'd1031);
    send_tick(1'b1, 32'd1032);
    send_tick(1'b0, 32'd1033);
    send_tick(1'b0, 32'd1054);
    send_tick(1'b0, 32'd1084);
    send_tick(1'b0, 32'd1200);
    send_tick(1'b1, 32'd1201);
  endtask

  // Widest settings with timestamps that wrap through zero, and a tick that
  // goes backwards in time.
  task automatic test_wide_settings();
    apply_config(16'hFFFF, 32'hFFFF_FFFF);
    send_tick(1'b0, 32'hFFFF_FFF0);
    send_tick(1'b0, 32'h0000_FFF0);
    send_tick(1'b0, 32'h0000_FFEF);
    send_tick(1'b1, 32'hFFFF_FFFF);
  endtask

  // Random press sequences: some bounce, a run of low ticks whose spacing is
  // scaled to the settings so that held and long hold can be reached, then
  // a release. One episode in five is noise with random levels and times.
  task automatic test_random_presses();
    int unsigned      phase;
    int unsigned      sent;
    int unsigned      n;
    int unsigned      k;
    longint unsigned  span;
    logic [TimeW-1:0] stamp;
    logic [15:0]      deb;
    logic [TimeW-1:0] hold;
    stamp = $urandom();
    for (phase = 0; phase < 7; phase++) begin
      case (phase)
        0: begin
          deb  = DebounceMsReset;
          hold = HoldMsReset;
        end
        1: begin
          deb  = 16'd0;
          hold = 32'd0;
        end
        2: begin
          deb  = 16'hFFFF;
          hold = 32'hFFFF_FFFF;
        end
        3, 4: begin
          deb  = 16'($urandom_range(0, 40));
          hold = $urandom_range(0, 200);
        end
        default: begin
          deb  = 16'($urandom_range(0, 65535));
          hold = $urandom();
        end
      endcase
      apply_config(deb, hold);
      calm = (phase % 3 == 1);
      span = (longint'(deb) + longint'(hold)) / 4 + 1;
      sent = 0;
      while (sent < 100) begin
        if ($urandom_range(0, 4) == 0) begin
          n = $urandom_range(1, 4);
          repeat (n) send_tick(1'($urandom_range(0, 1)), $urandom());
          sent += n;
        end else begin
          n = $urandom_range(0, 3);
          for (k = 0; k < n; k++) begin
            stamp += $urandom_range(0, int'(deb) / 2 + 1);
            send_tick(k[0], stamp);
          end
          sent += n;
          n = $urandom_range(1, 12);
          repeat (n) begin
            stamp += $urandom_range(0, 32'(span));
            send_tick(1'b0, stamp);
          end
          sent += n;
          n = $urandom_range(1, 3);
          repeat (n) begin
            stamp += $urandom_range(0, 32'(span));
            send_tick(1'b1, stamp);
          end
          sent += n;
        end
      end
    end
    calm = 1'b0;
  endtask

  // Result side: a random stall before each word, none in calm stretches.
  initial begin : result_sink
    int unsigned gap;
    wait (rst_n);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 17);
      @(negedge clk);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Scores every accepted result word against the oldest prediction.
  always @(posedge clk) begin : scoreboard
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_flags.size() == 0) begin
        mismatches++;
        $error("result word %0h arrived with no tick outstanding", out_tdata);
      end else begin
        want = expected_flags.pop_front();
        check_field("held", {3'd0, want.held}, {3'd0, out_tdata[0]});
        check_field("released", {3'd0, want.released}, {3'd0, out_tdata[1]});
        check_field("held_long", {3'd0, want.held_long}, {3'd0, out_tdata[2]});
        check_field("held_long_once", {3'd0, want.held_long_once},
                    {3'd0, out_tdata[3]});
        check_field("pad", 4'd0, out_tdata[7:4]);
      end
    end
  end

  // Hang detector: counts cycles with no handshake and no register write.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
        stall_count <= 0;
      end else begin
        stall_count <= stall_count + 1;
      end
      if (stall_count >= StallLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_zero_settings();
    test_bounce();
    test_wide_settings();
    test_random_presses();

    // Let the last words drain, then keep clocking the two-stage pipe so
    // that it can show any stray word.
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
